// ===== src/cets_pkg.sv =====
package cets_pkg;

    localparam int DP_W   = 56;
    localparam int FRAC_W = 40;
    localparam int PC_W   = 6;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [DP_W-1:0] dp_t;

    localparam dp_t DP_MAX = {1'b0, {(DP_W-1){1'b1}}};
    localparam dp_t DP_MIN = {1'b1, {(DP_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE3    = 3'd4;

    localparam logic [PC_W-1:0] SETUP_PC = 6'd0;
    localparam logic [PC_W-1:0] ITER_PC  = 6'd17;
    localparam logic [PC_W-1:0] SECT_PC  = 6'd32;

    typedef enum logic [2:0] {
        OP_MUL, OP_ADD, OP_SUB, OP_DBLSUB, OP_TRI
    } op_t;

    typedef enum logic [4:0] {
        SRC_ZERO, SRC_ARE, SRC_AIM, SRC_A2RE, SRC_A2IM, SRC_BRE, SRC_BIM,
        SRC_A2RE3, SRC_A2IM3, SRC_RE, SRC_IM, SRC_RE2, SRC_IM2, SRC_T1, SRC_T2,
        SRC_X1, SRC_X2, SRC_X3, SRC_SL1, SRC_SL2, SRC_SL3
    } src_t;

    typedef enum logic [3:0] {
        DST_A2RE, DST_A2IM, DST_BRE, DST_BIM, DST_A2RE3, DST_A2IM3, DST_RE, DST_IM,
        DST_RE2, DST_IM2, DST_T1, DST_T2, DST_X1, DST_X2, DST_X3
    } dst_t;

    typedef enum logic [1:0] {
        SEQ_NEXT, SEQ_CHECK, SEQ_DONE
    } seq_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_MWAIT, ST_CHECK, ST_RESULT
    } state_t;

    typedef struct packed {
        op_t  op;
        src_t sa;
        src_t sb;
        dst_t dst;
        seq_t seq;
        logic inc;
    } uop_t;

    typedef struct packed {
        logic load;
        op_t  op;
        src_t sa;
        src_t sb;
        dst_t dst;
        logic wr;
        logic wr_mul;
        logic mul_start;
        logic cnt_clr;
        logic cnt_inc;
        logic out_load;
        logic out_escaped;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic at_limit;
        logic esc;
        logic out_busy;
    } status_t;

    function automatic dp_t sat58(input logic signed [DP_W+1:0] v);
        dp_t r;
        if (v > (DP_W+2)'(DP_MAX))
            r = DP_MAX;
        else if (v < (DP_W+2)'(DP_MIN))
            r = DP_MIN;
        else
            r = v[DP_W-1:0];
        return r;
    endfunction

    function automatic uop_t mk(input op_t op, input src_t sa, input src_t sb,
                                input dst_t dst, input seq_t seq, input logic inc);
        uop_t u;
        u.op = op; u.sa = sa; u.sb = sb; u.dst = dst; u.seq = seq; u.inc = inc;
        return u;
    endfunction

    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            // setup: a^2, b = 2a^3 - a, 3a^2, then |z|^2 for z = a
            6'd0:  u = mk(OP_MUL,    SRC_ARE,  SRC_ARE,   DST_X1,    SEQ_NEXT,  1'b0);
            6'd1:  u = mk(OP_MUL,    SRC_AIM,  SRC_AIM,   DST_X2,    SEQ_NEXT,  1'b0);
            6'd2:  u = mk(OP_SUB,    SRC_X1,   SRC_X2,    DST_A2RE,  SEQ_NEXT,  1'b0);
            6'd3:  u = mk(OP_MUL,    SRC_ARE,  SRC_AIM,   DST_X1,    SEQ_NEXT,  1'b0);
            6'd4:  u = mk(OP_DBLSUB, SRC_X1,   SRC_ZERO,  DST_A2IM,  SEQ_NEXT,  1'b0);
            6'd5:  u = mk(OP_MUL,    SRC_A2RE, SRC_ARE,   DST_X1,    SEQ_NEXT,  1'b0);
            6'd6:  u = mk(OP_MUL,    SRC_A2IM, SRC_AIM,   DST_X2,    SEQ_NEXT,  1'b0);
            6'd7:  u = mk(OP_SUB,    SRC_X1,   SRC_X2,    DST_X1,    SEQ_NEXT,  1'b0);
            6'd8:  u = mk(OP_DBLSUB, SRC_X1,   SRC_ARE,   DST_BRE,   SEQ_NEXT,  1'b0);
            6'd9:  u = mk(OP_MUL,    SRC_A2RE, SRC_AIM,   DST_X1,    SEQ_NEXT,  1'b0);
            6'd10: u = mk(OP_MUL,    SRC_A2IM, SRC_ARE,   DST_X2,    SEQ_NEXT,  1'b0);
            6'd11: u = mk(OP_ADD,    SRC_X1,   SRC_X2,    DST_X1,    SEQ_NEXT,  1'b0);
            6'd12: u = mk(OP_DBLSUB, SRC_X1,   SRC_AIM,   DST_BIM,   SEQ_NEXT,  1'b0);
            6'd13: u = mk(OP_TRI,    SRC_A2RE, SRC_ZERO,  DST_A2RE3, SEQ_NEXT,  1'b0);
            6'd14: u = mk(OP_TRI,    SRC_A2IM, SRC_ZERO,  DST_A2IM3, SEQ_NEXT,  1'b0);
            6'd15: u = mk(OP_MUL,    SRC_RE,   SRC_RE,    DST_RE2,   SEQ_NEXT,  1'b0);
            6'd16: u = mk(OP_MUL,    SRC_IM,   SRC_IM,    DST_IM2,   SEQ_CHECK, 1'b0);
            // one step of z <- z^3 - 3a^2 z + b
            6'd17: u = mk(OP_SUB,    SRC_RE2,  SRC_IM2,   DST_X1,    SEQ_NEXT,  1'b0);
            6'd18: u = mk(OP_SUB,    SRC_X1,   SRC_A2RE3, DST_T1,    SEQ_NEXT,  1'b0);
            6'd19: u = mk(OP_MUL,    SRC_RE,   SRC_IM,    DST_X1,    SEQ_NEXT,  1'b0);
            6'd20: u = mk(OP_DBLSUB, SRC_X1,   SRC_A2IM3, DST_T2,    SEQ_NEXT,  1'b0);
            6'd21: u = mk(OP_MUL,    SRC_T1,   SRC_RE,    DST_X1,    SEQ_NEXT,  1'b0);
            6'd22: u = mk(OP_MUL,    SRC_T2,   SRC_IM,    DST_X2,    SEQ_NEXT,  1'b0);
            6'd23: u = mk(OP_SUB,    SRC_X1,   SRC_X2,    DST_X1,    SEQ_NEXT,  1'b0);
            6'd24: u = mk(OP_ADD,    SRC_X1,   SRC_BRE,   DST_X3,    SEQ_NEXT,  1'b0);
            6'd25: u = mk(OP_MUL,    SRC_T1,   SRC_IM,    DST_X1,    SEQ_NEXT,  1'b0);
            6'd26: u = mk(OP_MUL,    SRC_T2,   SRC_RE,    DST_X2,    SEQ_NEXT,  1'b0);
            6'd27: u = mk(OP_ADD,    SRC_X1,   SRC_X2,    DST_X1,    SEQ_NEXT,  1'b0);
            6'd28: u = mk(OP_ADD,    SRC_X1,   SRC_BIM,   DST_IM,    SEQ_NEXT,  1'b0);
            6'd29: u = mk(OP_ADD,    SRC_X3,   SRC_ZERO,  DST_RE,    SEQ_NEXT,  1'b0);
            6'd30: u = mk(OP_MUL,    SRC_RE,   SRC_RE,    DST_RE2,   SEQ_NEXT,  1'b0);
            6'd31: u = mk(OP_MUL,    SRC_IM,   SRC_IM,    DST_IM2,   SEQ_CHECK, 1'b1);
            // slope products for the sector test
            6'd32: u = mk(OP_MUL,    SRC_SL1,  SRC_RE,    DST_X1,    SEQ_NEXT,  1'b0);
            6'd33: u = mk(OP_MUL,    SRC_SL2,  SRC_RE,    DST_X2,    SEQ_NEXT,  1'b0);
            6'd34: u = mk(OP_MUL,    SRC_SL3,  SRC_RE,    DST_X3,    SEQ_DONE,  1'b0);
            default: u = mk(OP_ADD,  SRC_ZERO, SRC_ZERO,  DST_X3,    SEQ_DONE,  1'b0);
        endcase
        return u;
    endfunction

endpackage

// ===== src/cets_mul.sv =====
module cets_mul (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  cets_pkg::dp_t x,
    input  cets_pkg::dp_t y,
    output logic          done,
    output cets_pkg::dp_t p
);
    import cets_pkg::*;

    localparam int HW = DP_W / 2;
    localparam int AW = 2 * DP_W;

    logic [DP_W-1:0] ux_reg, uy_reg;
    logic            neg_reg;
    logic [AW-1:0]   acc_reg, acc_next;
    logic [2:0]      step_reg;
    logic            busy_reg, done_reg;
    dp_t             p_reg, p_next;
    logic [HW-1:0]   ha, hb;
    logic [2*HW-1:0] pp;
    logic [AW-1:0]   pp_sh;
    logic [AW-FRAC_W-1:0] mag;

    // 28x28 partial products, one per cycle: a0b0, a0b1, a1b0, a1b1
    always_comb begin
        ha = step_reg[1] ? ux_reg[DP_W-1:HW] : ux_reg[HW-1:0];
        hb = step_reg[0] ? uy_reg[DP_W-1:HW] : uy_reg[HW-1:0];
        pp = ha * hb;
        case (step_reg[1:0])
            2'd0:    pp_sh = AW'(pp);
            2'd3:    pp_sh = AW'(pp) << (2 * HW);
            default: pp_sh = AW'(pp) << HW;
        endcase
        acc_next = acc_reg + pp_sh;
    end

    // truncate toward zero, reapply sign, saturate
    always_comb begin
        mag = acc_reg[AW-1:FRAC_W];
        if (neg_reg) begin
            if (mag > (AW-FRAC_W)'({1'b1, {(DP_W-1){1'b0}}}))
                p_next = DP_MIN;
            else
                p_next = -$signed(mag[DP_W-1:0]);
        end else begin
            if (mag > (AW-FRAC_W)'(DP_MAX))
                p_next = DP_MAX;
            else
                p_next = $signed(mag[DP_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end else if (busy_reg) begin
                if (step_reg[2]) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ux_reg  <= x[DP_W-1] ? DP_W'(-x) : DP_W'(x);
            uy_reg  <= y[DP_W-1] ? DP_W'(-y) : DP_W'(y);
            neg_reg <= x[DP_W-1] ^ y[DP_W-1];
            acc_reg <= '0;
        end else if (busy_reg && !step_reg[2]) begin
            acc_reg <= acc_next;
        end
        if (busy_reg && step_reg[2])
            p_reg <= p_next;
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

// ===== src/cets_datapath.sv =====
module cets_datapath #(
    parameter int COUNT_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cets_pkg::cmd_t         cmd,
    output cets_pkg::status_t      status,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_wdata,
    input  logic signed [31:0]     s_a_real,
    input  logic signed [31:0]     s_a_imag,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_escaped,
    output logic [15:0]            m_escape_count,
    output logic [1:0]             m_sector
);
    import cets_pkg::*;

    localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [LW-1:0] CMAX = LW'((64'd1 << COUNT_BITS) - 64'd1);

    logic [15:0]        max_iter_reg;
    logic [11:0]        radius_sq_reg;
    logic signed [31:0] slope1_reg, slope2_reg, slope3_reg;

    dp_t are_reg, aim_reg, a2re_reg, a2im_reg, bre_reg, bim_reg, a2re3_reg, a2im3_reg;
    dp_t re_reg, im_reg, re2_reg, im2_reg, t1_reg, t2_reg, x1_reg, x2_reg, x3_reg;

    logic [COUNT_BITS-1:0] count_reg;
    logic                  m_valid_reg, escaped_reg;
    logic [15:0]           ecount_reg;
    logic [1:0]            sector_reg;

    dp_t  opa, opb, alu_y, wval, mul_p, dbl;
    logic mul_done;
    logic [LW-1:0] lim_ext, limit;
    logic signed [DP_W:0] mag_sum, bound;
    logic [1:0] sector_c;

    function automatic dp_t pick(input src_t s, input dp_t are, input dp_t aim,
                                 input dp_t a2re, input dp_t a2im, input dp_t bre,
                                 input dp_t bim, input dp_t a2re3, input dp_t a2im3,
                                 input dp_t re, input dp_t im, input dp_t re2,
                                 input dp_t im2, input dp_t t1, input dp_t t2,
                                 input dp_t x1, input dp_t x2, input dp_t x3,
                                 input dp_t sl1, input dp_t sl2, input dp_t sl3);
        dp_t r;
        case (s)
            SRC_ARE:   r = are;
            SRC_AIM:   r = aim;
            SRC_A2RE:  r = a2re;
            SRC_A2IM:  r = a2im;
            SRC_BRE:   r = bre;
            SRC_BIM:   r = bim;
            SRC_A2RE3: r = a2re3;
            SRC_A2IM3: r = a2im3;
            SRC_RE:    r = re;
            SRC_IM:    r = im;
            SRC_RE2:   r = re2;
            SRC_IM2:   r = im2;
            SRC_T1:    r = t1;
            SRC_T2:    r = t2;
            SRC_X1:    r = x1;
            SRC_X2:    r = x2;
            SRC_X3:    r = x3;
            SRC_SL1:   r = sl1;
            SRC_SL2:   r = sl2;
            SRC_SL3:   r = sl3;
            default:   r = '0;
        endcase
        return r;
    endfunction

    dp_t sl1, sl2, sl3;
    // Q8.24 -> Q16.40
    assign sl1 = dp_t'(slope1_reg) <<< 16;
    assign sl2 = dp_t'(slope2_reg) <<< 16;
    assign sl3 = dp_t'(slope3_reg) <<< 16;

    always_comb begin
        opa = pick(cmd.sa, are_reg, aim_reg, a2re_reg, a2im_reg, bre_reg, bim_reg,
                   a2re3_reg, a2im3_reg, re_reg, im_reg, re2_reg, im2_reg, t1_reg,
                   t2_reg, x1_reg, x2_reg, x3_reg, sl1, sl2, sl3);
        opb = pick(cmd.sb, are_reg, aim_reg, a2re_reg, a2im_reg, bre_reg, bim_reg,
                   a2re3_reg, a2im3_reg, re_reg, im_reg, re2_reg, im2_reg, t1_reg,
                   t2_reg, x1_reg, x2_reg, x3_reg, sl1, sl2, sl3);
    end

    always_comb begin
        dbl = sat58((DP_W+2)'(opa) <<< 1);
        case (cmd.op)
            OP_ADD:    alu_y = sat58((DP_W+2)'(opa) + (DP_W+2)'(opb));
            OP_SUB:    alu_y = sat58((DP_W+2)'(opa) - (DP_W+2)'(opb));
            OP_DBLSUB: alu_y = sat58((DP_W+2)'(dbl) - (DP_W+2)'(opb));
            OP_TRI:    alu_y = sat58((DP_W+2)'(opa) + ((DP_W+2)'(opa) <<< 1));
            default:   alu_y = opa;
        endcase
        wval = cmd.wr_mul ? mul_p : alu_y;
    end

    cets_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .x       (opa),
        .y       (opb),
        .done    (mul_done),
        .p       (mul_p)
    );

    always_comb begin
        lim_ext = LW'(max_iter_reg);
        limit   = (lim_ext > CMAX) ? CMAX : lim_ext;
        mag_sum = (DP_W+1)'(re2_reg) + (DP_W+1)'(im2_reg);
        bound   = $signed({1'b0, (DP_W-FRAC_W)'(radius_sq_reg), {FRAC_W{1'b0}}});
        if (x1_reg > im_reg && x2_reg < im_reg)
            sector_c = 2'd0;
        else if (x2_reg > im_reg && x3_reg > im_reg)
            sector_c = 2'd1;
        else
            sector_c = 2'd2;
    end

    assign status.mul_done = mul_done;
    assign status.at_limit = LW'(count_reg) >= limit;
    assign status.esc      = mag_sum >= bound;
    assign status.out_busy = m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg  <= 16'd100;
            radius_sq_reg <= 12'd100;
            slope1_reg    <= -32'sd138173796;
            slope2_reg    <= -32'sd8806360;
            slope3_reg    <= -32'sd44238163;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MAX_ITER:  max_iter_reg  <= cfg_wdata[15:0];
                CFG_RADIUS_SQ: radius_sq_reg <= cfg_wdata[11:0];
                CFG_SLOPE1:    slope1_reg    <= $signed(cfg_wdata);
                CFG_SLOPE2:    slope2_reg    <= $signed(cfg_wdata);
                CFG_SLOPE3:    slope3_reg    <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.cnt_clr)
                count_reg <= '0;
            else if (cmd.cnt_inc)
                count_reg <= count_reg + 1'b1;
            if (cmd.out_load)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            are_reg <= dp_t'(s_a_real) <<< 12;
            aim_reg <= dp_t'(s_a_imag) <<< 12;
            re_reg  <= dp_t'(s_a_real) <<< 12;
            im_reg  <= dp_t'(s_a_imag) <<< 12;
        end
        if (cmd.wr) begin
            case (cmd.dst)
                DST_A2RE:  a2re_reg  <= wval;
                DST_A2IM:  a2im_reg  <= wval;
                DST_BRE:   bre_reg   <= wval;
                DST_BIM:   bim_reg   <= wval;
                DST_A2RE3: a2re3_reg <= wval;
                DST_A2IM3: a2im3_reg <= wval;
                DST_RE:    re_reg    <= wval;
                DST_IM:    im_reg    <= wval;
                DST_RE2:   re2_reg   <= wval;
                DST_IM2:   im2_reg   <= wval;
                DST_T1:    t1_reg    <= wval;
                DST_T2:    t2_reg    <= wval;
                DST_X1:    x1_reg    <= wval;
                DST_X2:    x2_reg    <= wval;
                DST_X3:    x3_reg    <= wval;
                default: ;
            endcase
        end
        if (cmd.out_load) begin
            escaped_reg <= cmd.out_escaped;
            ecount_reg  <= cmd.out_escaped ? 16'(count_reg) : 16'd0;
            sector_reg  <= cmd.out_escaped ? sector_c : 2'd0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_escaped      = escaped_reg;
    assign m_escape_count = ecount_reg;
    assign m_sector       = sector_reg;

    ap_load_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> cmd.cnt_clr)
        else $error("input latched without clearing the count");
    ap_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid_reg && !m_ready))
        else $error("result overwritten before taken");
    ap_noesc_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.out_load) && !escaped_reg |-> ecount_reg == 16'd0 && sector_reg == 2'd0)
        else $error("non-escaped result carries count or sector");

endmodule

// ===== src/cets_ctrl.sv =====
module cets_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cets_pkg::status_t   status,
    output cets_pkg::cmd_t      cmd
);
    import cets_pkg::*;

    state_t          state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            esc_reg, esc_next;
    uop_t            uop;
    logic            advance;

    assign uop = ucode(pc_reg);

    always_comb begin
        advance = (state_reg == ST_EXEC && uop.op != OP_MUL) ||
                  (state_reg == ST_MWAIT && status.mul_done);
    end

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        esc_next   = esc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                    pc_next    = SETUP_PC;
                end
            end
            ST_EXEC, ST_MWAIT: begin
                if (state_reg == ST_EXEC && uop.op == OP_MUL)
                    state_next = ST_MWAIT;
                else if (advance) begin
                    case (uop.seq)
                        SEQ_NEXT: begin
                            state_next = ST_EXEC;
                            pc_next    = pc_reg + 1'b1;
                        end
                        SEQ_CHECK: state_next = ST_CHECK;
                        default:   state_next = ST_RESULT;
                    endcase
                end
            end
            ST_CHECK: begin
                state_next = ST_EXEC;
                if (status.at_limit) begin
                    esc_next   = 1'b0;
                    state_next = ST_RESULT;
                end else if (status.esc) begin
                    esc_next = 1'b1;
                    pc_next  = SECT_PC;
                end else begin
                    pc_next = ITER_PC;
                end
            end
            ST_RESULT: begin
                if (!status.out_busy)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.op          = uop.op;
        cmd.sa          = uop.sa;
        cmd.sb          = uop.sb;
        cmd.dst         = uop.dst;
        cmd.out_escaped = esc_reg;
        s_ready         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load    = s_valid;
                cmd.cnt_clr = s_valid;
            end
            ST_EXEC: begin
                cmd.mul_start = (uop.op == OP_MUL);
                cmd.wr        = advance;
                cmd.cnt_inc   = advance && uop.inc;
            end
            ST_MWAIT: begin
                cmd.wr      = advance;
                cmd.wr_mul  = advance;
                cmd.cnt_inc = advance && uop.inc;
            end
            ST_RESULT: cmd.out_load = !status.out_busy;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= SETUP_PC;
            esc_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            esc_reg   <= esc_next;
        end
    end

    ap_start_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_start |=> state_reg == ST_MWAIT)
        else $error("multiply issued without waiting for it");
    ap_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        status.mul_done |-> state_reg == ST_MWAIT)
        else $error("multiply result arrived outside wait state");
    ap_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_EXEC && pc_reg == SETUP_PC)
        else $error("accepted transaction did not start setup");

endmodule

// ===== src/cubic_escape_time_sector.sv =====
// Escape-time engine for z <- z^3 - 3a^2 z + b, b = 2a^3 - a, z0 = a, one
// transaction per pixel a (Q4.28), worked in saturating Q16.40. All products
// share one 56x56 multiplier that takes four 28x28 partial products and a
// rounding step; a microcoded sequencer walks the steps. A pixel runs the
// setup up to the first bound check, then one iteration for each check that
// neither escapes nor hits the limit; an escaping pixel then runs the
// sector test, and one at the limit goes straight to the result load; that
// load waits while an earlier result is still held in the output register.
// One pixel is in flight at a time; the result sits in an output register so
// the next pixel can be taken while it waits. Configuration writes land at
// once and must only be issued while idle.
module cubic_escape_time_sector #(
    parameter int COUNT_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_a_real,
    input  logic signed [31:0] s_a_imag,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_escaped,
    output logic [15:0]        m_escape_count,
    output logic [1:0]         m_sector
);
    import cets_pkg::*;

    cmd_t    cmd;
    status_t status;

    cets_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cets_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_a_real       (s_a_real),
        .s_a_imag       (s_a_imag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_escaped      (m_escaped),
        .m_escape_count (m_escape_count),
        .m_sector       (m_sector)
    );

endmodule
